// File: rtl/swtb_pkg.sv
// Shared constants and types for the software timer bank.
// Used by every module of the block; depends on nothing.
package swtb_pkg;

  localparam int NUM_TIMERS   = 8;
  localparam int TIMER_SEL_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int MODE_W       = 3;
  localparam int INDEX_W      = 3;
  localparam int COUNT_W      = 32;
  localparam int MASK_W       = 8;
  localparam int APB_ADDR_W   = 1;
  localparam int APB_DATA_W   = 32;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 32'h7FFF_FFFF;

  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STOP  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SET   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

  localparam logic [APB_ADDR_W-1:0] ADDR_COUNT_UP_MASK = 1'd0;

  typedef struct packed {
    logic tick;
    logic start;
    logic stop;
    logic set;
    logic load;
  } swtb_cmd_t;

endpackage

// File: rtl/swtb_ctrl.sv
// Controller: request handshake, mode decode and result register occupancy.
// Depends on swtb_pkg.
module swtb_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swtb_pkg::MODE_W-1:0]   in_mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output swtb_pkg::swtb_cmd_t           cmd
);

  typedef enum logic {
    OUT_EMPTY,
    OUT_FULL
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   fire;

  assign in_stall  = (state_r == OUT_FULL) && out_stall;
  assign fire      = in_valid && !in_stall;
  assign out_valid = (state_r == OUT_FULL);

  always_comb begin
    cmd = '0;
    if (fire) begin
      case (in_mode)
        swtb_pkg::MODE_TICK:  cmd.tick  = 1'b1;
        swtb_pkg::MODE_START: cmd.start = 1'b1;
        swtb_pkg::MODE_STOP:  cmd.stop  = 1'b1;
        swtb_pkg::MODE_SET:   cmd.set   = 1'b1;
        swtb_pkg::MODE_READ:  cmd.load  = 1'b1;
        default:              cmd       = '0;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      OUT_EMPTY: if (cmd.load) state_nxt = OUT_FULL;
      OUT_FULL: begin
        if (!cmd.load && !out_stall) state_nxt = OUT_EMPTY;
      end
      default: state_nxt = OUT_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= OUT_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/swtb_dp.sv
// Datapath: timer counts, run flags, direction register and result register.
// Depends on swtb_pkg; driven by swtb_ctrl commands.
module swtb_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  swtb_pkg::swtb_cmd_t               cmd,
  input  logic [swtb_pkg::INDEX_W-1:0]      in_timer_index,
  input  logic [swtb_pkg::COUNT_W-1:0]      in_set_value,
  output logic [swtb_pkg::COUNT_W-1:0]      out_read_value,
  output logic                              out_read_active,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swtb_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [swtb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [swtb_pkg::APB_DATA_W-1:0]   prdata
);

  logic [swtb_pkg::COUNT_W-1:0]     count_r  [swtb_pkg::NUM_TIMERS];
  logic [swtb_pkg::COUNT_W-1:0]     count_nxt[swtb_pkg::NUM_TIMERS];
  logic [swtb_pkg::NUM_TIMERS-1:0]  active_r;
  logic [swtb_pkg::NUM_TIMERS-1:0]  active_nxt;
  logic [swtb_pkg::MASK_W-1:0]      mask_r;
  logic [swtb_pkg::COUNT_W-1:0]     read_value_r;
  logic                             read_active_r;
  logic [swtb_pkg::TIMER_SEL_W-1:0] sel;
  logic                             idx_ok;
  logic                             cfg_wr;

  assign sel    = in_timer_index[swtb_pkg::TIMER_SEL_W-1:0];
  assign idx_ok = ({1'b0, in_timer_index} < (swtb_pkg::INDEX_W+1)'(swtb_pkg::NUM_TIMERS));
  assign cfg_wr = psel && penable && pwrite && (paddr == swtb_pkg::ADDR_COUNT_UP_MASK);
  assign prdata = (paddr == swtb_pkg::ADDR_COUNT_UP_MASK) ?
                  {{(swtb_pkg::APB_DATA_W-swtb_pkg::MASK_W){1'b0}}, mask_r} : '0;

  always_comb begin
    for (int i = 0; i < swtb_pkg::NUM_TIMERS; i++) begin
      count_nxt[i]  = count_r[i];
      active_nxt[i] = active_r[i];
      if (cmd.tick && active_r[i]) begin
        if (mask_r[i]) begin
          if (count_r[i] < swtb_pkg::COUNT_LIMIT) count_nxt[i] = count_r[i] + 1'b1;
        end else begin
          if (count_r[i] != '0) count_nxt[i] = count_r[i] - 1'b1;
        end
      end
      if (idx_ok && (sel == swtb_pkg::TIMER_SEL_W'(i))) begin
        if (cmd.start) active_nxt[i] = 1'b1;
        if (cmd.stop)  active_nxt[i] = 1'b0;
        if (cmd.set)   count_nxt[i]  = in_set_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      mask_r   <= '0;
      for (int i = 0; i < swtb_pkg::NUM_TIMERS; i++) count_r[i] <= '0;
    end else begin
      active_r <= active_nxt;
      for (int i = 0; i < swtb_pkg::NUM_TIMERS; i++) count_r[i] <= count_nxt[i];
      if (cfg_wr) mask_r <= pwdata[swtb_pkg::MASK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      read_value_r  <= idx_ok ? count_r[sel] : '0;
      read_active_r <= idx_ok && active_r[sel];
    end
  end

  assign out_read_value  = read_value_r;
  assign out_read_active = read_active_r;

endmodule

// File: rtl/software_timer_bank_unit.sv
// Top level of the software timer bank: controller plus datapath.
// Depends on swtb_pkg, swtb_ctrl and swtb_dp.
//
// Eight 32-bit timers that step together on a tick request (up-counters
// saturate at 2^31-1, down-counters at 0); start, stop, set and read address
// one timer. A request can be accepted each clock while in_stall is low; a
// read places its result in a one-entry output register, and in_stall
// rises only while that register is full and out_stall holds it.
// Direction bits live in count_up_mask at APB byte address 0. Reset clears
// all counts, run flags and the mask.
module software_timer_bank_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [swtb_pkg::MODE_W-1:0]       in_mode,
  input  logic [swtb_pkg::INDEX_W-1:0]      in_timer_index,
  input  logic [swtb_pkg::COUNT_W-1:0]      in_set_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [swtb_pkg::COUNT_W-1:0]      out_read_value,
  output logic                              out_read_active,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swtb_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [swtb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [swtb_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  swtb_pkg::swtb_cmd_t cmd;

  assign pready = 1'b1;

  swtb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  swtb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_timer_index  (in_timer_index),
    .in_set_value    (in_set_value),
    .out_read_value  (out_read_value),
    .out_read_active (out_read_active),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
  );

endmodule

// File: rtl/swtb_checker.sv
// Port-level checks for software_timer_bank_unit, attached by bind.
// Depends on swtb_pkg.
module swtb_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [swtb_pkg::MODE_W-1:0]       in_mode,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [swtb_pkg::COUNT_W-1:0]      out_read_value,
  input  logic                              out_read_active
);

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value)
                               && $stable(out_read_active))
    else $error("held result changed");

  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == swtb_pkg::MODE_READ) |=> out_valid)
    else $error("accepted read produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode != swtb_pkg::MODE_READ)
    && (!out_valid || !out_stall) |=> !out_valid)
    else $error("result without read request");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind software_timer_bank_unit swtb_checker u_swtb_checker (.*);
